@@ design/strict_priority_frame_queues_defines.svh @@
// Assertion macros for the strict priority frame queues.
`ifndef STRICT_PRIORITY_FRAME_QUEUES_DEFINES_SVH
`define STRICT_PRIORITY_FRAME_QUEUES_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SPFQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spfq: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SPFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spfq: next-cycle check failed");

`endif

@@ design/spfq_pkg.sv @@
package spfq_pkg;

    localparam int QUEUE_DEPTH = 4096;
    localparam int CLASS_COUNT = 3;
    localparam int MAX_PAYLOAD = 1024;

    localparam int HDR_BYTES = 4;
    localparam int REQ_W     = 3;
    localparam int CLS_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int BACKLOG_W = 13;

    typedef logic [REQ_W-1:0] req_t;

    localparam req_t REQ_PUSH_HDR   = 3'd0;
    localparam req_t REQ_PUSH_BYTE  = 3'd1;
    localparam req_t REQ_TAKE_FRAME = 3'd2;
    localparam req_t REQ_TAKE_BYTE  = 3'd3;
    localparam req_t REQ_CLEAR      = 3'd4;
    localparam req_t REQ_QUERY      = 3'd5;

    typedef struct packed {
        logic       load_req;
        logic       calc_used;
        logic       latch_act;
        logic       clear;
        logic       set_acc;
        logic       set_fail;
        logic       wr_en;
        logic       rd_en;
        logic [1:0] step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        req_t req_type;
        logic cls_ok;
        logic link_open;
        logic fits;
        logic room_nz;
        logic elig_any;
        logic drain_zero;
        logic drain_ok;
    } status_t;

endpackage

@@ design/spfq_ram.sv @@
module spfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/spfq_ctrl.sv @@
`include "strict_priority_frame_queues_defines.svh"

module spfq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  spfq_pkg::status_t sts,
    output spfq_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_POST = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] last_step_reg, last_step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        last_step_next = last_step_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_PRE;
                end
            end
            ST_PRE: begin
                cmd.calc_used = 1'b1;
                state_next    = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.latch_act = 1'b1;
                step_next     = 2'd0;
                state_next    = ST_POST;
                case (sts.req_type)
                    spfq_pkg::REQ_PUSH_HDR: begin
                        if (sts.cls_ok && sts.link_open) begin
                            if (!sts.fits) begin
                                cmd.set_fail = 1'b1;
                            end else begin
                                cmd.set_acc    = 1'b1;
                                last_step_next = 2'd3;
                                state_next     = ST_WR;
                            end
                        end
                    end
                    spfq_pkg::REQ_PUSH_BYTE: begin
                        if (sts.cls_ok && sts.room_nz) begin
                            cmd.set_acc    = 1'b1;
                            last_step_next = 2'd0;
                            state_next     = ST_WR;
                        end
                    end
                    spfq_pkg::REQ_TAKE_FRAME: begin
                        if (sts.link_open && sts.drain_zero && sts.elig_any) begin
                            cmd.set_acc    = 1'b1;
                            last_step_next = 2'd3;
                            state_next     = ST_RD;
                        end
                    end
                    spfq_pkg::REQ_TAKE_BYTE: begin
                        if (sts.cls_ok && sts.drain_ok) begin
                            cmd.set_acc    = 1'b1;
                            last_step_next = 2'd0;
                            state_next     = ST_RD;
                        end
                    end
                    spfq_pkg::REQ_CLEAR: begin
                        cmd.clear   = 1'b1;
                        cmd.set_acc = 1'b1;
                    end
                    spfq_pkg::REQ_QUERY: begin
                        cmd.set_acc = sts.cls_ok;
                    end
                    default: begin
                    end
                endcase
            end
            ST_WR: begin
                cmd.wr_en = 1'b1;
                cmd.step  = step_reg;
                if (step_reg == last_step_reg) begin
                    state_next = ST_POST;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_RD: begin
                cmd.rd_en = 1'b1;
                cmd.step  = step_reg;
                if (step_reg == last_step_reg) begin
                    state_next = ST_POST;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_POST: begin
                cmd.calc_used = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            last_step_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_step_reg <= last_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    `SPFQ_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SPFQ_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out, !out_valid_reg || m_ready)
    `SPFQ_ASSERT_NOW(a_step_bound, aclk, aresetn, state_reg == ST_WR || state_reg == ST_RD, step_reg <= last_step_reg)

endmodule

@@ design/spfq_dp.sv @@
module spfq_dp #(
    parameter int QUEUE_DEPTH = spfq_pkg::QUEUE_DEPTH,
    parameter int CLASS_COUNT = spfq_pkg::CLASS_COUNT,
    parameter int MAX_PAYLOAD = spfq_pkg::MAX_PAYLOAD
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  spfq_pkg::cmd_t                    cmd,
    output spfq_pkg::status_t                 sts,
    input  spfq_pkg::req_t                    s_req_type,
    input  logic [spfq_pkg::CLS_W-1:0]        s_cls,
    input  logic [spfq_pkg::BYTE_W-1:0]       s_frame_type,
    input  logic [spfq_pkg::BYTE_W-1:0]       s_channel,
    input  logic [spfq_pkg::LEN_W-1:0]        s_payload_len,
    input  logic [spfq_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_link_open,
    output logic                              m_accepted,
    output logic                              m_link_fail,
    output logic                              m_frame_valid,
    output logic [spfq_pkg::CLS_W-1:0]        m_out_class,
    output logic [spfq_pkg::BYTE_W-1:0]       m_out_type,
    output logic [spfq_pkg::BYTE_W-1:0]       m_out_channel,
    output logic [spfq_pkg::LEN_W-1:0]        m_out_len,
    output logic [spfq_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_last_byte,
    output logic [spfq_pkg::BACKLOG_W-1:0]    m_backlog_bytes,
    output logic                              m_fits
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int UW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(CLASS_COUNT);
    localparam int AW = $clog2(CLASS_COUNT * QUEUE_DEPTH);
    localparam int SW = ((UW > spfq_pkg::LEN_W) ? UW : spfq_pkg::LEN_W) + 2;
    localparam int BW = spfq_pkg::BYTE_W;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
        return (v == IW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    spfq_pkg::req_t              req_type_reg;
    logic [spfq_pkg::CLS_W-1:0]  cls_reg;
    logic [BW-1:0]               ftype_reg, chan_reg, dbyte_reg;
    logic [spfq_pkg::LEN_W-1:0]  plen_reg;
    logic                        open_reg;

    logic [IW-1:0] wr_idx_reg [CLASS_COUNT];
    logic [IW-1:0] rd_idx_reg [CLASS_COUNT];
    logic          wr_ph_reg  [CLASS_COUNT];
    logic          rd_ph_reg  [CLASS_COUNT];
    logic [UW-1:0] used_reg   [CLASS_COUNT];

    logic [CW-1:0]              drain_cls_reg, act_cls_reg;
    logic [spfq_pkg::LEN_W-1:0] drain_left_reg;
    logic                       acc_reg, fail_reg;
    logic [BW-1:0]              hdr_reg [spfq_pkg::HDR_BYTES];
    logic [BW-1:0]              byte_reg;
    logic                       last_reg;
    logic                       rd_pend_reg;
    logic [1:0]                 rd_step_reg;

    logic [UW-1:0]      used_calc [CLASS_COUNT];
    logic [UW:0]        diff      [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] elig;
    logic [CW-1:0]      sel_cls, cls_idx;
    logic               cls_ok, drain_cls_ok, fits_calc, is_tf, is_tb;
    logic [UW-1:0]      used_cls;
    logic [SW-1:0]      need, used_wide;
    logic [AW-1:0]      waddr, raddr;
    logic [BW-1:0]      wdata, rdata;

    assign cls_idx      = CW'(cls_reg);
    assign cls_ok       = 32'(cls_reg) < 32'(CLASS_COUNT);
    assign drain_cls_ok = 32'(drain_cls_reg) < 32'(CLASS_COUNT);
    assign is_tf        = (req_type_reg == spfq_pkg::REQ_TAKE_FRAME);
    assign is_tb        = (req_type_reg == spfq_pkg::REQ_TAKE_BYTE);

    always_comb begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            diff[c] = (UW+1)'(wr_idx_reg[c]) - (UW+1)'(rd_idx_reg[c]);
            if (wr_ph_reg[c] != rd_ph_reg[c]) begin
                diff[c] = diff[c] + (UW+1)'(QUEUE_DEPTH);
            end
            used_calc[c] = diff[c][UW-1:0];
            elig[c]      = used_reg[c] >= UW'(spfq_pkg::HDR_BYTES);
        end
    end

    always_comb begin
        sel_cls = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (elig[c]) begin
                sel_cls = CW'(c);
            end
        end
    end

    assign used_cls  = cls_ok ? used_reg[cls_idx] : '0;
    assign used_wide = SW'(used_cls);
    assign need      = used_wide + SW'(spfq_pkg::HDR_BYTES) + SW'(plen_reg);
    assign fits_calc = cls_ok && (plen_reg <= spfq_pkg::LEN_W'(MAX_PAYLOAD))
                       && (need <= SW'(QUEUE_DEPTH));

    always_comb begin
        sts.req_type   = req_type_reg;
        sts.cls_ok     = cls_ok;
        sts.link_open  = open_reg;
        sts.fits       = fits_calc;
        sts.room_nz    = cls_ok && (used_cls != UW'(QUEUE_DEPTH));
        sts.elig_any   = |elig;
        sts.drain_zero = (drain_left_reg == '0);
        sts.drain_ok   = (drain_left_reg != '0) && drain_cls_ok
                         && (used_reg[drain_cls_reg] != '0);
    end

    always_comb begin
        case (cmd.step)
            2'd0:    wdata = (req_type_reg == spfq_pkg::REQ_PUSH_BYTE) ? dbyte_reg : ftype_reg;
            2'd1:    wdata = chan_reg;
            2'd2:    wdata = plen_reg[BW-1:0];
            default: wdata = plen_reg[2*BW-1:BW];
        endcase
    end

    assign waddr = AW'(act_cls_reg) * AW'(QUEUE_DEPTH) + AW'(wr_idx_reg[act_cls_reg]);
    assign raddr = AW'(act_cls_reg) * AW'(QUEUE_DEPTH) + AW'(rd_idx_reg[act_cls_reg]);

    spfq_ram #(
        .WIDTH(BW),
        .DEPTH(CLASS_COUNT * QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                wr_idx_reg[c] <= '0;
                rd_idx_reg[c] <= '0;
                wr_ph_reg[c]  <= 1'b0;
                rd_ph_reg[c]  <= 1'b0;
            end
            drain_cls_reg  <= '0;
            drain_left_reg <= '0;
            rd_pend_reg    <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
            if (cmd.clear) begin
                for (int c = 0; c < CLASS_COUNT; c++) begin
                    wr_idx_reg[c] <= '0;
                    rd_idx_reg[c] <= '0;
                    wr_ph_reg[c]  <= 1'b0;
                    rd_ph_reg[c]  <= 1'b0;
                end
                drain_cls_reg  <= '0;
                drain_left_reg <= '0;
            end
            if (cmd.set_acc && is_tf) begin
                drain_cls_reg <= sel_cls;
            end
            if (cmd.wr_en) begin
                wr_idx_reg[act_cls_reg] <= idx_inc(wr_idx_reg[act_cls_reg]);
                if (wr_idx_reg[act_cls_reg] == IW'(QUEUE_DEPTH - 1)) begin
                    wr_ph_reg[act_cls_reg] <= !wr_ph_reg[act_cls_reg];
                end
            end
            if (cmd.rd_en) begin
                rd_idx_reg[act_cls_reg] <= idx_inc(rd_idx_reg[act_cls_reg]);
                if (rd_idx_reg[act_cls_reg] == IW'(QUEUE_DEPTH - 1)) begin
                    rd_ph_reg[act_cls_reg] <= !rd_ph_reg[act_cls_reg];
                end
            end
            if (cmd.rd_en && is_tb) begin
                drain_left_reg <= drain_left_reg - 1'b1;
            end else if (rd_pend_reg && is_tf && rd_step_reg == 2'd3) begin
                drain_left_reg <= {rdata, hdr_reg[2]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_step_reg <= cmd.step;
        if (cmd.load_req) begin
            req_type_reg <= s_req_type;
            cls_reg      <= s_cls;
            ftype_reg    <= s_frame_type;
            chan_reg     <= s_channel;
            plen_reg     <= s_payload_len;
            dbyte_reg    <= s_data_byte;
            open_reg     <= s_link_open;
            acc_reg      <= 1'b0;
            fail_reg     <= 1'b0;
        end
        if (cmd.set_acc) begin
            acc_reg <= 1'b1;
        end
        if (cmd.set_fail) begin
            fail_reg <= 1'b1;
        end
        if (cmd.calc_used) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                used_reg[c] <= used_calc[c];
            end
        end
        if (cmd.latch_act) begin
            if (is_tf) begin
                act_cls_reg <= sel_cls;
            end else if (is_tb) begin
                act_cls_reg <= drain_cls_reg;
            end else begin
                act_cls_reg <= cls_idx;
            end
        end
        if (cmd.rd_en && is_tb) begin
            last_reg <= (drain_left_reg == spfq_pkg::LEN_W'(1));
        end
        if (rd_pend_reg) begin
            if (is_tb) begin
                byte_reg <= rdata;
            end else begin
                hdr_reg[rd_step_reg] <= rdata;
            end
        end
        if (cmd.load_out) begin
            m_accepted      <= acc_reg;
            m_link_fail     <= fail_reg;
            m_frame_valid   <= acc_reg && is_tf;
            m_out_class     <= (acc_reg && is_tf) ? spfq_pkg::CLS_W'(act_cls_reg) : '0;
            m_out_type      <= (acc_reg && is_tf) ? hdr_reg[0] : '0;
            m_out_channel   <= (acc_reg && is_tf) ? hdr_reg[1] : '0;
            m_out_len       <= (acc_reg && is_tf) ? {hdr_reg[3], hdr_reg[2]} : '0;
            m_out_byte      <= (acc_reg && is_tb) ? byte_reg : '0;
            m_last_byte     <= acc_reg && is_tb && last_reg;
            m_backlog_bytes <= used_wide[spfq_pkg::BACKLOG_W-1:0];
            m_fits          <= fits_calc;
        end
    end

endmodule

@@ design/strict_priority_frame_queues.sv @@
// Channel   Ports                          Moves
// input     s_valid s_ready s_*            one request per handshake
// result    m_valid m_ready m_*            one result per request
//
// One request at a time. A request runs through PRE, EVAL, a write or read phase for
// byte access, POST and FIN before its result is loaded; push header and take frame make
// four byte accesses on the RAM shared by all classes; s_ready rises with m_valid.
// A waiting result holds only the next request, in its last cycle, until m_ready.
// Reset is synchronous, active low; it empties every class and cancels the drain.
// Byte store contents are not cleared.

module strict_priority_frame_queues #(
    parameter int QUEUE_DEPTH = spfq_pkg::QUEUE_DEPTH,
    parameter int CLASS_COUNT = spfq_pkg::CLASS_COUNT,
    parameter int MAX_PAYLOAD = spfq_pkg::MAX_PAYLOAD
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  spfq_pkg::req_t                 s_req_type,
    input  logic [spfq_pkg::CLS_W-1:0]     s_cls,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_frame_type,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_channel,
    input  logic [spfq_pkg::LEN_W-1:0]     s_payload_len,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_link_open,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic                           m_link_fail,
    output logic                           m_frame_valid,
    output logic [spfq_pkg::CLS_W-1:0]     m_out_class,
    output logic [spfq_pkg::BYTE_W-1:0]    m_out_type,
    output logic [spfq_pkg::BYTE_W-1:0]    m_out_channel,
    output logic [spfq_pkg::LEN_W-1:0]     m_out_len,
    output logic [spfq_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                           m_last_byte,
    output logic [spfq_pkg::BACKLOG_W-1:0] m_backlog_bytes,
    output logic                           m_fits
);

    spfq_pkg::cmd_t    cmd;
    spfq_pkg::status_t sts;

    spfq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    spfq_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .CLASS_COUNT(CLASS_COUNT),
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_cls          (s_cls),
        .s_frame_type   (s_frame_type),
        .s_channel      (s_channel),
        .s_payload_len  (s_payload_len),
        .s_data_byte    (s_data_byte),
        .s_link_open    (s_link_open),
        .m_accepted     (m_accepted),
        .m_link_fail    (m_link_fail),
        .m_frame_valid  (m_frame_valid),
        .m_out_class    (m_out_class),
        .m_out_type     (m_out_type),
        .m_out_channel  (m_out_channel),
        .m_out_len      (m_out_len),
        .m_out_byte     (m_out_byte),
        .m_last_byte    (m_last_byte),
        .m_backlog_bytes(m_backlog_bytes),
        .m_fits         (m_fits)
    );

endmodule

@@ tb/strict_priority_frame_queues_checker.sv @@
`timescale 1ns / 1ps

module strict_priority_frame_queues_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  spfq_pkg::req_t                 s_req_type,
    input  logic [spfq_pkg::CLS_W-1:0]     s_cls,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_frame_type,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_channel,
    input  logic [spfq_pkg::LEN_W-1:0]     s_payload_len,
    input  logic [spfq_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_link_open,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_accepted,
    input  logic                           m_link_fail,
    input  logic                           m_frame_valid,
    input  logic [spfq_pkg::CLS_W-1:0]     m_out_class,
    input  logic [spfq_pkg::BYTE_W-1:0]    m_out_type,
    input  logic [spfq_pkg::BYTE_W-1:0]    m_out_channel,
    input  logic [spfq_pkg::LEN_W-1:0]     m_out_len,
    input  logic [spfq_pkg::BYTE_W-1:0]    m_out_byte,
    input  logic                           m_last_byte,
    input  logic [spfq_pkg::BACKLOG_W-1:0] m_backlog_bytes,
    input  logic                           m_fits,
    output int                             err_count,
    output int                             pending,
    output int                             requests_seen,
    output int                             results_seen
);

    localparam int PTR_W = $clog2(2 * spfq_pkg::QUEUE_DEPTH);

    typedef struct packed {
        logic                           accepted;
        logic                           link_fail;
        logic                           frame_valid;
        logic [spfq_pkg::CLS_W-1:0]     out_class;
        logic [spfq_pkg::BYTE_W-1:0]    out_type;
        logic [spfq_pkg::BYTE_W-1:0]    out_channel;
        logic [spfq_pkg::LEN_W-1:0]     out_len;
        logic [spfq_pkg::BYTE_W-1:0]    out_byte;
        logic                           last_byte;
        logic [spfq_pkg::BACKLOG_W-1:0] backlog;
        logic                           fits;
    } queue_result_t;

    logic [spfq_pkg::BYTE_W-1:0] ring_mem [spfq_pkg::CLASS_COUNT * spfq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]            wr_ptr [spfq_pkg::CLASS_COUNT];
    logic [PTR_W-1:0]            rd_ptr [spfq_pkg::CLASS_COUNT];
    int                          drain_cls;
    int                          drain_left;
    queue_result_t               expected_results [$];

    function automatic int class_used(input int c);
        logic [PTR_W-1:0] u;
        u = wr_ptr[c] - rd_ptr[c];
        return int'(u);
    endfunction

    function automatic int class_room(input int c);
        int u;
        u = class_used(c);
        return (u >= spfq_pkg::QUEUE_DEPTH) ? 0 : spfq_pkg::QUEUE_DEPTH - u;
    endfunction

    function automatic bit frame_fits(input int c, input int plen);
        if (plen > spfq_pkg::MAX_PAYLOAD) return 1'b0;
        return class_room(c) >= spfq_pkg::HDR_BYTES + plen;
    endfunction

    task automatic ring_put(input int c, input int b);
        ring_mem[c * spfq_pkg::QUEUE_DEPTH + (int'(wr_ptr[c]) % spfq_pkg::QUEUE_DEPTH)] = 8'(b);
        wr_ptr[c] = wr_ptr[c] + 1'b1;
    endtask

    task automatic ring_get(input int c, output logic [spfq_pkg::BYTE_W-1:0] b);
        b = ring_mem[c * spfq_pkg::QUEUE_DEPTH + (int'(rd_ptr[c]) % spfq_pkg::QUEUE_DEPTH)];
        rd_ptr[c] = rd_ptr[c] + 1'b1;
    endtask

    task automatic clear_queues();
        for (int c = 0; c < spfq_pkg::CLASS_COUNT; c++) begin
            wr_ptr[c] = '0;
            rd_ptr[c] = '0;
        end
        drain_cls = 0;
        drain_left = 0;
    endtask

    task automatic predict_result(input spfq_pkg::req_t req, input int c, input int ftype,
                                  input int chan, input int plen, input int dbyte,
                                  input bit open, output queue_result_t r);
        bit                          cls_ok;
        int                          k;
        logic [spfq_pkg::BYTE_W-1:0] b0;
        logic [spfq_pkg::BYTE_W-1:0] b1;
        logic [spfq_pkg::BYTE_W-1:0] b2;
        logic [spfq_pkg::BYTE_W-1:0] b3;
        r = '0;
        cls_ok = c < spfq_pkg::CLASS_COUNT;
        case (req)
            spfq_pkg::REQ_PUSH_HDR: begin
                if (cls_ok && open) begin
                    if (!frame_fits(c, plen)) begin
                        r.link_fail = 1'b1;
                    end else begin
                        ring_put(c, ftype);
                        ring_put(c, chan);
                        ring_put(c, plen & 8'hFF);
                        ring_put(c, plen >> 8);
                        r.accepted = 1'b1;
                    end
                end
            end
            spfq_pkg::REQ_PUSH_BYTE: begin
                if (cls_ok && class_room(c) > 0) begin
                    ring_put(c, dbyte);
                    r.accepted = 1'b1;
                end
            end
            spfq_pkg::REQ_TAKE_FRAME: begin
                if (open && drain_left == 0) begin
                    k = 0;
                    while (k < spfq_pkg::CLASS_COUNT && class_used(k) < spfq_pkg::HDR_BYTES) k++;
                    if (k < spfq_pkg::CLASS_COUNT) begin
                        ring_get(k, b0);
                        ring_get(k, b1);
                        ring_get(k, b2);
                        ring_get(k, b3);
                        r.out_type = b0;
                        r.out_channel = b1;
                        r.out_len = {b3, b2};
                        r.out_class = 2'(k);
                        drain_cls = k;
                        drain_left = int'(r.out_len);
                        r.frame_valid = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
            end
            spfq_pkg::REQ_TAKE_BYTE: begin
                if (cls_ok && drain_left != 0 && drain_cls < spfq_pkg::CLASS_COUNT &&
                    class_used(drain_cls) > 0) begin
                    ring_get(drain_cls, b0);
                    r.out_byte = b0;
                    drain_left--;
                    r.last_byte = drain_left == 0;
                    r.accepted = 1'b1;
                end
            end
            spfq_pkg::REQ_CLEAR: begin
                clear_queues();
                r.accepted = 1'b1;
            end
            spfq_pkg::REQ_QUERY: begin
                r.accepted = cls_ok;
            end
            default: begin
            end
        endcase
        if (cls_ok) begin
            r.backlog = 13'(class_used(c));
            r.fits = frame_fits(c, plen);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (err_count < 10)
                $display("result %0d: %s expected 0x%0h got 0x%0h",
                         results_seen, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        queue_result_t want;
        queue_result_t got;
        if (!aresetn) begin
            clear_queues();
            expected_results.delete();
            err_count = 0;
            requests_seen = 0;
            results_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_accepted, m_link_fail, m_frame_valid, m_out_class, m_out_type,
                       m_out_channel, m_out_len, m_out_byte, m_last_byte,
                       m_backlog_bytes, m_fits};
                if (expected_results.size() == 0) begin
                    if (err_count < 10)
                        $display("result %0d arrived with no request outstanding",
                                 results_seen);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("link_fail", want.link_fail, got.link_fail);
                    check_field("frame_valid", want.frame_valid, got.frame_valid);
                    check_field("out_class", want.out_class, got.out_class);
                    check_field("out_type", want.out_type, got.out_type);
                    check_field("out_channel", want.out_channel, got.out_channel);
                    check_field("out_len", want.out_len, got.out_len);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("last_byte", want.last_byte, got.last_byte);
                    check_field("backlog_bytes", want.backlog, got.backlog);
                    check_field("fits", want.fits, got.fits);
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predict_result(s_req_type, int'(s_cls), int'(s_frame_type),
                               int'(s_channel), int'(s_payload_len), int'(s_data_byte),
                               s_link_open, want);
                expected_results.push_back(want);
                requests_seen++;
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/strict_priority_frame_queues_tb.sv @@
`timescale 1ns / 1ps

module strict_priority_frame_queues_tb;

    localparam int             RAND_ITEMS   = 900;
    localparam int             MAX_GAP      = 18;
    localparam int             HOLD_AT      = 40;
    localparam int             HOLD_CYCLES  = 400;
    localparam int             QUIET_LIMIT  = 3000;
    localparam int             DRAIN_CYCLES = 40;
    localparam spfq_pkg::req_t REQ_SPARE_6  = 3'd6;
    localparam spfq_pkg::req_t REQ_SPARE_7  = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    spfq_pkg::req_t                 s_req_type;
    logic [spfq_pkg::CLS_W-1:0]     s_cls;
    logic [spfq_pkg::BYTE_W-1:0]    s_frame_type;
    logic [spfq_pkg::BYTE_W-1:0]    s_channel;
    logic [spfq_pkg::LEN_W-1:0]     s_payload_len;
    logic [spfq_pkg::BYTE_W-1:0]    s_data_byte;
    logic                           s_link_open;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_accepted;
    logic                           m_link_fail;
    logic                           m_frame_valid;
    logic [spfq_pkg::CLS_W-1:0]     m_out_class;
    logic [spfq_pkg::BYTE_W-1:0]    m_out_type;
    logic [spfq_pkg::BYTE_W-1:0]    m_out_channel;
    logic [spfq_pkg::LEN_W-1:0]     m_out_len;
    logic [spfq_pkg::BYTE_W-1:0]    m_out_byte;
    logic                           m_last_byte;
    logic [spfq_pkg::BACKLOG_W-1:0] m_backlog_bytes;
    logic                           m_fits;

    int err_count;
    int pending;
    int requests_seen;
    int results_seen;
    int tx_count = 0;
    int rx_count = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;
    bit held_off = 1'b0;

    always #6 aclk = ~aclk;

    strict_priority_frame_queues uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_cls           (s_cls),
        .s_frame_type    (s_frame_type),
        .s_channel       (s_channel),
        .s_payload_len   (s_payload_len),
        .s_data_byte     (s_data_byte),
        .s_link_open     (s_link_open),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_link_fail     (m_link_fail),
        .m_frame_valid   (m_frame_valid),
        .m_out_class     (m_out_class),
        .m_out_type      (m_out_type),
        .m_out_channel   (m_out_channel),
        .m_out_len       (m_out_len),
        .m_out_byte      (m_out_byte),
        .m_last_byte     (m_last_byte),
        .m_backlog_bytes (m_backlog_bytes),
        .m_fits          (m_fits)
    );

    strict_priority_frame_queues_checker frame_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_cls           (s_cls),
        .s_frame_type    (s_frame_type),
        .s_channel       (s_channel),
        .s_payload_len   (s_payload_len),
        .s_data_byte     (s_data_byte),
        .s_link_open     (s_link_open),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_link_fail     (m_link_fail),
        .m_frame_valid   (m_frame_valid),
        .m_out_class     (m_out_class),
        .m_out_type      (m_out_type),
        .m_out_channel   (m_out_channel),
        .m_out_len       (m_out_len),
        .m_out_byte      (m_out_byte),
        .m_last_byte     (m_last_byte),
        .m_backlog_bytes (m_backlog_bytes),
        .m_fits          (m_fits),
        .err_count       (err_count),
        .pending         (pending),
        .requests_seen   (requests_seen),
        .results_seen    (results_seen)
    );

    function automatic int rand_byte();
        return $urandom_range(0, 255);
    endfunction

    function automatic int any_len();
        if ($urandom_range(0, 1) != 0) return $urandom_range(0, spfq_pkg::MAX_PAYLOAD + 76);
        return $urandom_range(0, 65535);
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic issue_request(input spfq_pkg::req_t req, input int cls, input int ftype,
                                 input int chan, input int plen, input int dbyte,
                                 input int open);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_cls         <= 2'(cls);
        s_frame_type  <= 8'(ftype);
        s_channel     <= 8'(chan);
        s_payload_len <= 16'(plen);
        s_data_byte   <= 8'(dbyte);
        s_link_open   <= (open != 0);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        tx_count++;
    endtask

    task automatic push_frame(input int cls, input int ftype, input int chan,
                              input int plen, input int nbytes, input int open);
        issue_request(spfq_pkg::REQ_PUSH_HDR, cls, ftype, chan, plen, rand_byte(), open);
        repeat (nbytes)
            issue_request(spfq_pkg::REQ_PUSH_BYTE, cls, rand_byte(), rand_byte(), any_len(),
                          rand_byte(), $urandom_range(0, 1));
    endtask

    task automatic take_run(input int open, input int count);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, $urandom_range(0, 3), rand_byte(),
                      rand_byte(), any_len(), rand_byte(), open);
        repeat (count)
            issue_request(spfq_pkg::REQ_TAKE_BYTE,
                          ($urandom_range(0, 31) == 0) ? 3 : $urandom_range(0, 2),
                          rand_byte(), rand_byte(), any_len(), rand_byte(),
                          $urandom_range(0, 1));
    endtask

    initial begin : result_sink
        int hold;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held_off && rx_count >= HOLD_AT) begin
                hold = HOLD_CYCLES;
                held_off = 1'b1;
            end else begin
                hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            rx_count++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", quiet_cycles);
            $display("strict_priority_frame_queues_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int c;
        int plen;
        int nbytes;
        int roll;
        int pick;
        int open;
        int rand_goal;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= spfq_pkg::REQ_QUERY;
        s_cls         <= '0;
        s_frame_type  <= '0;
        s_channel     <= '0;
        s_payload_len <= '0;
        s_data_byte   <= '0;
        s_link_open   <= 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        issue_request(spfq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 0, 8'hAA, 8'h55, 4, 0, 0);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 0, 8'h11, 8'h22, spfq_pkg::MAX_PAYLOAD + 1,
                      0, 1);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 1, 8'h33, 8'h44, 16'hFFFF, 0, 1);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 3, 8'h66, 8'h77, 0, 0, 1);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 2, 8'hFF, 8'h00, 2, 8'h00, 1);
        issue_request(spfq_pkg::REQ_PUSH_BYTE, 2, 0, 0, 0, 8'hFF, 1);
        issue_request(spfq_pkg::REQ_PUSH_BYTE, 2, 0, 0, 0, 8'h00, 0);
        issue_request(spfq_pkg::REQ_PUSH_HDR, 0, 8'h00, 8'hFF, 0, 8'hFF, 1);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 0);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 3, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 2, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 2, 0, 0, spfq_pkg::MAX_PAYLOAD, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 2, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_QUERY, 3, 0, 0, spfq_pkg::MAX_PAYLOAD, 0, 1);
        issue_request(REQ_SPARE_6, 3, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1);
        issue_request(REQ_SPARE_7, 3, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1);
        // short payload, then a stray byte on a class with no header
        push_frame(1, 8'h5A, 8'hA5, 3, 1, 1);
        issue_request(spfq_pkg::REQ_PUSH_BYTE, 0, 0, 0, 0, 8'h3C, 1);
        issue_request(spfq_pkg::REQ_TAKE_FRAME, 0, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 1, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_TAKE_BYTE, 1, 0, 0, 0, 0, 1);
        issue_request(spfq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        issue_request(spfq_pkg::REQ_QUERY, 1, 0, 0, spfq_pkg::MAX_PAYLOAD, 0, 1);

        rand_goal = tx_count + RAND_ITEMS;
        while (tx_count < rand_goal) begin
            if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                c = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
                roll = $urandom_range(0, 99);
                if (roll < 82) plen = $urandom_range(0, 24);
                else if (roll < 93) plen = $urandom_range(25, 160);
                else if (roll < 94) plen = $urandom_range(161, spfq_pkg::MAX_PAYLOAD);
                else plen = $urandom_range(spfq_pkg::MAX_PAYLOAD + 1, 65535);
                open = ($urandom_range(0, 15) != 0);
                nbytes = (open != 0 && c < spfq_pkg::CLASS_COUNT &&
                          plen <= spfq_pkg::MAX_PAYLOAD) ? plen : 0;
                if (pick < 4) nbytes = $urandom_range(0, nbytes);
                push_frame(c, rand_byte(), rand_byte(), plen, nbytes, open);
            end else if (pick < 70) begin
                take_run($urandom_range(0, 15) != 0, $urandom_range(0, 40));
            end else if (pick < 82) begin
                issue_request(spfq_pkg::REQ_QUERY, $urandom_range(0, 3), rand_byte(),
                              rand_byte(), any_len(), rand_byte(), $urandom_range(0, 1));
            end else if (pick < 85) begin
                issue_request(spfq_pkg::REQ_CLEAR, $urandom_range(0, 3), rand_byte(),
                              rand_byte(), any_len(), rand_byte(), $urandom_range(0, 1));
            end else if (pick < 89) begin
                issue_request(($urandom_range(0, 1) != 0) ? REQ_SPARE_6 : REQ_SPARE_7,
                              $urandom_range(0, 3), rand_byte(), rand_byte(), any_len(),
                              rand_byte(), $urandom_range(0, 1));
            end else if (pick < 95) begin
                issue_request(spfq_pkg::REQ_PUSH_BYTE, $urandom_range(0, 3), rand_byte(),
                              rand_byte(), any_len(), rand_byte(), $urandom_range(0, 1));
            end else begin
                issue_request(spfq_pkg::REQ_TAKE_BYTE, $urandom_range(0, 3), rand_byte(),
                              rand_byte(), any_len(), rand_byte(), $urandom_range(0, 1));
            end
        end

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 requests_seen, results_seen, err_count);
        $display("run covered refusals, priority order, drains, spare codes and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (err_count == 0 && pending == 0) begin
            $display("strict_priority_frame_queues_tb: clean");
        end else begin
            $display("strict_priority_frame_queues_tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/spfq_pkg.sv
design/spfq_ram.sv
design/spfq_ctrl.sv
design/spfq_dp.sv
design/strict_priority_frame_queues.sv
tb/strict_priority_frame_queues_checker.sv
tb/strict_priority_frame_queues_tb.sv
